/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(name, clock, rstn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clock, rstn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// condition never holds
`define ASSERT_NEVER(name, clock, rstn, expr) \
    name: assert property (@(posedge clock) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

/* src/prgs_pkg.sv */
package prgs_pkg;

    typedef struct packed {
        logic       command;
        logic [5:0] source_node;
        logic [5:0] target_node;
    } prgs_cmd_t;

    typedef struct packed {
        logic [5:0]  node_index;
        logic [31:0] rank;
        logic [31:0] squared_change;
        logic        last_of_run;
    } prgs_res_t;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_START    = 1'b1;

    localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] REG_SWEEP_COUNT = 2'd1;
    localparam logic [1:0] REG_DAMPING     = 2'd2;

    localparam logic [6:0]  NODE_COUNT_RST  = 7'd64;
    localparam logic [7:0]  SWEEP_COUNT_RST = 8'd110;
    localparam logic [14:0] DAMPING_RST     = 15'd27853;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam int CNT_W     = 7;
    localparam int DEG_W     = 7;
    localparam int RANK_W    = 32;
    localparam int CON_W     = 47;
    localparam int NUM_W     = 54;
    localparam int DVD_W     = 61;
    localparam int DVS_W     = 22;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_INIT_START,
        ST_INIT_WAIT,
        ST_INIT_RD,
        ST_INIT_CHK,
        ST_INIT_CWAIT,
        ST_NODE_RD,
        ST_NODE_BIAS,
        ST_ACC,
        ST_SELF_MUL,
        ST_SELF_DIV,
        ST_RANK,
        ST_DIFF,
        ST_SQ,
        ST_SUM,
        ST_CON_WAIT,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } prgs_state_t;

endpackage

/* src/pagerank_gauss_seidel_top.sv */
// channel | dir | handshake                          | payload
// cmd     | in  | cmd_valid / cmd_ready              | prgs_cmd_t
// res     | out | res_valid / res_ready              | prgs_res_t
// apb     | in  | psel, penable, pwrite, pready = 1  | paddr, pwdata, prdata
//
// an add-edge beat reads the column and degree stores, then writes back a new edge
// a start beat divides out the initial rank, writes it to each node and divides the
// contribution of each node with links out; per sweep and node it then accumulates the
// links in, then uses the shared 61-step divider for a self link and for links out
// each rank beat reads the rank store, loads the result register, then waits on res_ready
// reset clears control state and the stores' valid bits; registers return to their defaults
// the cmd channel stalls from a start beat until the last rank beat is taken
module pagerank_gauss_seidel_top #(
    parameter int MAX_NODES     = 64,
    parameter int FRACTION_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  prgs_pkg::prgs_cmd_t cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output prgs_pkg::prgs_res_t res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import prgs_pkg::*;

    localparam int NL = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int AW = $clog2(NL);

    function automatic logic [RANK_W-1:0] sat32(input logic [DVD_W-1:0] v);
        logic [RANK_W-1:0] r;
        r = (|v[DVD_W-1:RANK_W]) ? '1 : v[RANK_W-1:0];
        return r;
    endfunction

    // config registers
    logic [6:0]  node_count_reg;
    logic [7:0]  sweep_count_reg;
    logic [14:0] damping_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= NODE_COUNT_RST;
            sweep_count_reg <= SWEEP_COUNT_RST;
            damping_reg     <= DAMPING_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_NODE_COUNT:  node_count_reg  <= pwdata[6:0];
                REG_SWEEP_COUNT: sweep_count_reg <= pwdata[7:0];
                REG_DAMPING:     damping_reg     <= pwdata[14:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NODE_COUNT:  prdata = 32'(node_count_reg);
            REG_SWEEP_COUNT: prdata = 32'(sweep_count_reg);
            REG_DAMPING:     prdata = 32'(damping_reg);
            default:         prdata = '0;
        endcase
    end

    logic [CNT_W-1:0] n_eff;
    assign n_eff = (node_count_reg == '0) ? CNT_W'(1) :
                   ((node_count_reg > CNT_W'(NL)) ? CNT_W'(NL) : node_count_reg);

    // state and control
    prgs_state_t      state_reg, state_next;
    logic [AW-1:0]    i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [7:0]       sweep_reg;
    logic [CNT_W-1:0] n_reg;
    logic             pend_reg;
    logic             res_valid_reg;

    // payload
    logic [AW-1:0]     src_reg, tgt_reg, pj_reg;
    logic [RANK_W-1:0] init_reg, old_reg, rank_reg, diff_reg, change_reg;
    logic [CON_W-1:0]  cprod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NL-1:0]     col_reg;
    logic [DEG_W-1:0]  degi_reg;
    logic [63:0]       sq_reg;
    prgs_res_t         res_reg;

    // memories
    logic [RANK_W-1:0] rnow_mem [NL];
    logic [RANK_W-1:0] rbef_mem [NL];
    logic [CON_W-1:0]  con_mem  [NL];
    logic [NL-1:0]     col_mem  [NL];
    logic [DEG_W-1:0]  deg_mem  [NL];

    logic [RANK_W-1:0] rnow_q, rbef_q, rnow_wdata, rbef_wdata;
    logic [CON_W-1:0]  con_q, con_wdata;
    logic [NL-1:0]     col_q, col_wdata, col_eff;
    logic [DEG_W-1:0]  deg_q, deg_wdata, deg_eff;
    logic              rnow_re, rnow_we, rbef_re, rbef_we, con_re, con_we;
    logic              col_re, col_we, deg_re, deg_we;
    logic [AW-1:0]     rnow_raddr, rnow_waddr, rbef_addr, con_raddr, con_waddr;
    logic [AW-1:0]     col_raddr, col_waddr, deg_raddr, deg_waddr;
    logic [NL-1:0]     col_vld_reg, deg_vld_reg;
    logic              col_qv_reg, deg_qv_reg;
    logic              clr;

    // divider
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DVD_W-1:0]     div_quo_reg, div_dvd;
    logic [DVS_W-1:0]     div_rem_reg, div_dvs_reg, div_dvs;
    logic                 div_start, div_busy, div_ge;
    logic [DVS_W:0]       div_sh, div_sub;
    logic                 div_wait_st;

    logic cmd_ready_c, node_done, last_i, last_j, final_sweep, self_c, in_range, new_sweep;
    logic [47:0]       bias_prod;
    logic [RANK_W:0]   change_sum_w;
    logic [64:0]       change_sum;

    assign col_eff     = col_qv_reg ? col_q : '0;
    assign deg_eff     = deg_qv_reg ? deg_q : '0;
    assign last_i      = (CNT_W'(i_reg) == n_reg - CNT_W'(1));
    assign last_j      = (j_reg == n_reg - CNT_W'(1));
    assign final_sweep = (sweep_reg == sweep_count_reg - 8'd1);
    assign self_c      = col_reg[i_reg] && (degi_reg != '0);
    assign in_range    = ({1'b0, cmd.source_node} < 7'(NL)) &&
                         ({1'b0, cmd.target_node} < 7'(NL));
    assign new_sweep   = node_done && last_i && !final_sweep;
    assign div_busy    = (div_cnt_reg != '0);
    assign div_wait_st = (state_reg == ST_INIT_WAIT) || (state_reg == ST_INIT_CWAIT) ||
                         (state_reg == ST_SELF_DIV) || (state_reg == ST_CON_WAIT);
    assign bias_prod   = 48'(ONE_Q15 - {1'b0, damping_reg}) * 48'(rbef_q);
    assign change_sum  = 65'(change_reg) + 65'(sq_reg >> FRACTION_BITS);
    assign change_sum_w = (|change_sum[64:RANK_W]) ? {1'b0, {RANK_W{1'b1}}}
                                                   : {1'b0, change_sum[RANK_W-1:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.command == CMD_START)
                        state_next = ST_INIT_START;
                    else if (in_range)
                        state_next = ST_EDGE_WR;
                end
            end
            ST_EDGE_WR:    state_next = ST_IDLE;
            ST_INIT_START: state_next = ST_INIT_WAIT;
            ST_INIT_WAIT:  if (!div_busy) state_next = ST_INIT_RD;
            ST_INIT_RD:    state_next = ST_INIT_CHK;
            ST_INIT_CHK:
            begin
                if (deg_eff != '0)
                    state_next = ST_INIT_CWAIT;
                else if (!last_j)
                    state_next = ST_INIT_RD;
                else
                    state_next = (sweep_count_reg == '0) ? ST_OUT_RD : ST_NODE_RD;
            end
            ST_INIT_CWAIT:
            begin
                if (!div_busy)
                begin
                    if (!last_j)
                        state_next = ST_INIT_RD;
                    else
                        state_next = (sweep_count_reg == '0) ? ST_OUT_RD : ST_NODE_RD;
                end
            end
            ST_NODE_RD:    state_next = ST_NODE_BIAS;
            ST_NODE_BIAS:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (j_reg == n_reg)
                    state_next = self_c ? ST_SELF_MUL : ST_RANK;
            end
            ST_SELF_MUL:   state_next = ST_SELF_DIV;
            ST_SELF_DIV:   if (!div_busy) state_next = ST_RANK;
            ST_RANK:       state_next = ST_DIFF;
            ST_DIFF:       state_next = ST_SQ;
            ST_SQ:         state_next = ST_SUM;
            ST_SUM:
            begin
                if (degi_reg != '0)
                    state_next = ST_CON_WAIT;
                else if (last_i && final_sweep)
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_NODE_RD;
            end
            ST_CON_WAIT:
            begin
                if (!div_busy)
                    state_next = (last_i && final_sweep) ? ST_OUT_RD : ST_NODE_RD;
            end
            ST_OUT_RD:     state_next = ST_OUT_LOAD;
            ST_OUT_LOAD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (res_ready)
                    state_next = last_i ? ST_IDLE : ST_OUT_RD;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        cmd_ready_c = 1'b0;
        rnow_re = 1'b0; rnow_raddr = i_reg;
        rnow_we = 1'b0; rnow_waddr = i_reg; rnow_wdata = rank_reg;
        rbef_re = 1'b0; rbef_we = 1'b0; rbef_addr = i_reg; rbef_wdata = rnow_q;
        con_re = 1'b0; con_raddr = j_reg[AW-1:0];
        con_we = 1'b0; con_waddr = i_reg; con_wdata = '0;
        col_re = 1'b0; col_raddr = i_reg;
        col_we = 1'b0; col_waddr = tgt_reg; col_wdata = col_eff | (NL'(1) << src_reg);
        deg_re = 1'b0; deg_raddr = i_reg;
        deg_we = 1'b0; deg_waddr = src_reg; deg_wdata = deg_eff + DEG_W'(1);
        div_start = 1'b0; div_dvd = '0; div_dvs = '0;
        node_done = 1'b0;
        clr = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready_c = 1'b1;
                col_re = 1'b1;
                col_raddr = cmd.target_node[AW-1:0];
                deg_re = 1'b1;
                deg_raddr = cmd.source_node[AW-1:0];
            end
            ST_EDGE_WR:
            begin
                if (!col_eff[src_reg])
                begin
                    col_we = 1'b1;
                    deg_we = 1'b1;
                end
            end
            ST_INIT_START:
            begin
                div_start = 1'b1;
                div_dvd = DVD_W'(1) << FRACTION_BITS;
                div_dvs = DVS_W'(n_reg);
            end
            ST_INIT_RD:
            begin
                rnow_we = 1'b1;
                rnow_waddr = j_reg[AW-1:0];
                rnow_wdata = init_reg;
                rbef_we = 1'b1;
                rbef_addr = j_reg[AW-1:0];
                rbef_wdata = init_reg;
                deg_re = 1'b1;
                deg_raddr = j_reg[AW-1:0];
            end
            ST_INIT_CHK:
            begin
                if (deg_eff == '0)
                begin
                    con_we = 1'b1;
                    con_waddr = j_reg[AW-1:0];
                end
                else
                begin
                    div_start = 1'b1;
                    div_dvd = DVD_W'(cprod_reg);
                    div_dvs = DVS_W'(deg_eff);
                end
            end
            ST_INIT_CWAIT:
            begin
                if (!div_busy)
                begin
                    con_we = 1'b1;
                    con_waddr = j_reg[AW-1:0];
                    con_wdata = div_quo_reg[CON_W-1:0];
                end
            end
            ST_NODE_RD:
            begin
                rnow_re = 1'b1;
                rbef_re = 1'b1;
                col_re = 1'b1;
                deg_re = 1'b1;
            end
            ST_NODE_BIAS:
            begin
                rbef_we = 1'b1;
            end
            ST_ACC:
            begin
                con_re = (j_reg < n_reg);
            end
            ST_SELF_MUL:
            begin
                div_start = 1'b1;
                div_dvd = DVD_W'(num_reg) * DVD_W'(degi_reg);
                div_dvs = DVS_W'({degi_reg, 15'b0}) - DVS_W'(damping_reg);
            end
            ST_DIFF:
            begin
                rnow_we = 1'b1;
            end
            ST_SUM:
            begin
                if (degi_reg == '0)
                begin
                    con_we = 1'b1;
                    node_done = 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                    div_dvd = DVD_W'(cprod_reg);
                    div_dvs = DVS_W'(degi_reg);
                end
            end
            ST_CON_WAIT:
            begin
                if (!div_busy)
                begin
                    con_we = 1'b1;
                    con_wdata = div_quo_reg[CON_W-1:0];
                    node_done = 1'b1;
                end
            end
            ST_OUT_RD:
            begin
                rnow_re = 1'b1;
            end
            ST_OUT_WAIT:
            begin
                clr = res_ready && last_i;
            end
            default: ;
        endcase
    end

    assign cmd_ready = cmd_ready_c;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // memory ports
    always_ff @(posedge clk)
    begin
        if (rnow_we)
            rnow_mem[rnow_waddr] <= rnow_wdata;
        if (rnow_re)
            rnow_q <= rnow_mem[rnow_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rbef_we)
            rbef_mem[rbef_addr] <= rbef_wdata;
        if (rbef_re)
            rbef_q <= rbef_mem[rbef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (con_we)
            con_mem[con_waddr] <= con_wdata;
        if (con_re)
            con_q <= con_mem[con_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[col_waddr] <= col_wdata;
        if (col_re)
            col_q <= col_mem[col_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_waddr] <= deg_wdata;
        if (deg_re)
            deg_q <= deg_mem[deg_raddr];
    end

    // valid bits for the cleared stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg <= '0;
            deg_vld_reg <= '0;
            col_qv_reg  <= 1'b0;
            deg_qv_reg  <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                col_vld_reg <= '0;
                deg_vld_reg <= '0;
            end
            else
            begin
                if (col_we)
                    col_vld_reg[col_waddr] <= 1'b1;
                if (deg_we)
                    deg_vld_reg[deg_waddr] <= 1'b1;
            end
            if (col_re)
                col_qv_reg <= col_vld_reg[col_raddr];
            if (deg_re)
                deg_qv_reg <= deg_vld_reg[deg_raddr];
        end
    end

    // restoring divider, one quotient bit per cycle
    assign div_sh  = {div_rem_reg, div_quo_reg[DVD_W-1]};
    assign div_ge  = (div_sh >= {1'b0, div_dvs_reg});
    assign div_sub = div_sh - {1'b0, div_dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (div_start)
            div_cnt_reg <= DIV_CNT_W'(DVD_W);
        else if (div_busy)
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_quo_reg <= div_dvd;
            div_rem_reg <= '0;
            div_dvs_reg <= div_dvs;
        end
        else if (div_busy)
        begin
            div_quo_reg <= {div_quo_reg[DVD_W-2:0], div_ge};
            div_rem_reg <= div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            sweep_reg     <= '0;
            n_reg         <= CNT_W'(1);
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && (cmd.command == CMD_START))
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        sweep_reg <= '0;
                        n_reg     <= n_eff;
                    end
                end
                ST_INIT_CHK:
                begin
                    if ((deg_eff == '0) && !last_j)
                        j_reg <= j_reg + CNT_W'(1);
                end
                ST_INIT_CWAIT:
                begin
                    if (!div_busy && !last_j)
                        j_reg <= j_reg + CNT_W'(1);
                end
                ST_NODE_BIAS:
                begin
                    j_reg    <= '0;
                    pend_reg <= 1'b0;
                end
                ST_ACC:
                begin
                    pend_reg <= (j_reg < n_reg);
                    if (j_reg < n_reg)
                        j_reg <= j_reg + CNT_W'(1);
                end
                ST_OUT_LOAD:
                begin
                    res_valid_reg <= 1'b1;
                end
                ST_OUT_WAIT:
                begin
                    if (res_ready)
                    begin
                        res_valid_reg <= 1'b0;
                        if (!last_i)
                            i_reg <= i_reg + AW'(1);
                    end
                end
                default: ;
            endcase
            if (node_done)
            begin
                if (!last_i)
                    i_reg <= i_reg + AW'(1);
                else
                begin
                    i_reg <= '0;
                    if (!final_sweep)
                        sweep_reg <= sweep_reg + 8'd1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                src_reg    <= cmd.source_node[AW-1:0];
                tgt_reg    <= cmd.target_node[AW-1:0];
                change_reg <= '0;
            end
            ST_INIT_WAIT:
            begin
                if (!div_busy)
                    init_reg <= sat32(div_quo_reg);
            end
            ST_INIT_RD:
            begin
                cprod_reg <= CON_W'(damping_reg) * CON_W'(init_reg);
            end
            ST_NODE_BIAS:
            begin
                num_reg  <= NUM_W'({bias_prod[47:15], 15'b0});
                old_reg  <= rnow_q;
                col_reg  <= col_eff;
                degi_reg <= deg_eff;
            end
            ST_ACC:
            begin
                if (pend_reg && col_reg[pj_reg] && (pj_reg != i_reg))
                    num_reg <= num_reg + NUM_W'(con_q);
                pj_reg <= j_reg[AW-1:0];
            end
            ST_RANK:
            begin
                rank_reg <= self_c ? sat32(div_quo_reg) : sat32(DVD_W'(num_reg >> 15));
            end
            ST_DIFF:
            begin
                diff_reg  <= (rank_reg >= old_reg) ? rank_reg - old_reg : old_reg - rank_reg;
                cprod_reg <= CON_W'(damping_reg) * CON_W'(rank_reg);
            end
            ST_SQ:
            begin
                sq_reg <= 64'(diff_reg) * 64'(diff_reg);
            end
            ST_SUM:
            begin
                change_reg <= new_sweep ? '0 : change_sum_w[RANK_W-1:0];
            end
            ST_CON_WAIT:
            begin
                if (new_sweep)
                    change_reg <= '0;
            end
            ST_OUT_LOAD:
            begin
                res_reg.node_index     <= 6'(i_reg);
                res_reg.rank           <= rnow_q;
                res_reg.squared_change <= change_reg;
                res_reg.last_of_run    <= last_i;
            end
            default: ;
        endcase
    end

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_no_cmd_during_result, clk, rst_n, cmd_ready && res_valid)
    `ASSERT_IMPL(a_div_only_in_wait, clk, rst_n, div_busy, div_wait_st)
    `ASSERT_IMPL(a_last_is_top_node, clk, rst_n, res_valid && res.last_of_run, CNT_W'(res.node_index) == n_reg - CNT_W'(1))
    `ASSERT_NEXT(a_store_cleared, clk, rst_n, res_valid && res_ready && res.last_of_run, (col_vld_reg == '0) && (deg_vld_reg == '0))

endmodule

/* test/pagerank_gauss_seidel_top_tb.sv */
`timescale 1ns / 1ps

module pagerank_gauss_seidel_top_tb;
    import prgs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    prgs_cmd_t   cmd;
    logic        res_valid;
    logic        res_ready;
    prgs_res_t   res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pagerank_gauss_seidel_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    prgs_cmd_t   pending_cmds[$];
    prgs_res_t   expected_ranks[$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          beat_taken = 0;
    bit          steady_mode = 0;
    int          send_gap = 0;
    int          recv_gap = 0;

    // shadow of the block
    bit [63:0]   adj_rows[64];
    bit [6:0]    degree[64];
    bit [31:0]   rank_cur[64];
    bit [31:0]   rank_prev[64];
    bit [31:0]   bias[64];
    bit [6:0]    cfg_nodes;
    bit [7:0]    cfg_sweeps;
    bit [14:0]   cfg_damping;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_mode || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic bit [31:0] sat32(bit [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic bit [63:0] gs_sweep(int n);
        bit [63:0] d;
        bit [63:0] num;
        bit [63:0] mul;
        bit [63:0] den;
        bit [63:0] dif;
        bit [63:0] change;
        d = 64'(cfg_damping);
        change = 0;
        for (int i = 0; i < n; i++)
        begin
            bias[i] = 32'(((64'd32768 - d) * 64'(rank_prev[i])) >> 15);
            rank_prev[i] = rank_cur[i];
            num = 64'(bias[i]) << 15;
            for (int j = 0; j < n; j++)
                if (j != i && adj_rows[j][i] && degree[j] != 0)
                    num += (d * 64'(rank_cur[j])) / 64'(degree[j]);
            if (adj_rows[i][i] && degree[i] != 0)
            begin
                mul = 64'(degree[i]);
                den = 64'd32768 * mul - d;
            end
            else
            begin
                mul = 1;
                den = 64'd32768;
            end
            rank_cur[i] = sat32((num * mul) / den);
        end
        for (int i = 0; i < n; i++)
        begin
            dif = (rank_cur[i] > rank_prev[i]) ? 64'(rank_cur[i] - rank_prev[i])
                                                : 64'(rank_prev[i] - rank_cur[i]);
            change += (dif * dif) >> 30;
            if (change > 64'hFFFF_FFFF)
                change = 64'hFFFF_FFFF;
        end
        return change;
    endfunction

    task automatic predict_ranks(prgs_cmd_t c);
        int n;
        bit [63:0] change;
        prgs_res_t r;
        if (c.command == CMD_ADD_EDGE)
        begin
            if (!adj_rows[c.source_node][c.target_node])
            begin
                adj_rows[c.source_node][c.target_node] = 1;
                degree[c.source_node]++;
            end
            return;
        end
        n = int'(cfg_nodes);
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        for (int i = 0; i < n; i++)
        begin
            rank_cur[i] = sat32((64'd1 << 30) / 64'(n));
            rank_prev[i] = rank_cur[i];
        end
        change = 0;
        for (int s = 0; s < int'(cfg_sweeps); s++)
            change = gs_sweep(n);
        for (int i = 0; i < n; i++)
        begin
            r.node_index = 6'(i);
            r.rank = rank_cur[i];
            r.squared_change = change[31:0];
            r.last_of_run = (i == n - 1);
            expected_ranks.push_back(r);
        end
        for (int i = 0; i < 64; i++)
        begin
            adj_rows[i] = 0;
            degree[i] = 0;
        end
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_NODE_COUNT:  cfg_nodes = value[6:0];
            REG_SWEEP_COUNT: cfg_sweeps = value[7:0];
            REG_DAMPING:     cfg_damping = value[14:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 0;
        penable <= 0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_ranks.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(int n, int sw, int dmp);
        wait_drained();
        apb_write(REG_NODE_COUNT, 32'(n));
        apb_write(REG_SWEEP_COUNT, 32'(sw));
        apb_write(REG_DAMPING, 32'(dmp));
    endtask

    task automatic push_edge(int s, int t);
        prgs_cmd_t c;
        c.command = CMD_ADD_EDGE;
        c.source_node = 6'(s);
        c.target_node = 6'(t);
        pending_cmds.push_back(c);
    endtask

    task automatic push_start();
        prgs_cmd_t c;
        c.command = CMD_START;
        c.source_node = 6'($urandom);
        c.target_node = 6'($urandom);
        pending_cmds.push_back(c);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 0;
            cmd <= '0;
        end
        else if (!cmd_valid || beat_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 0;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd <= pending_cmds.pop_front();
                cmd_valid <= 1;
                send_gap = pick_gap();
            end
            else
                cmd_valid <= 0;
        end
        beat_taken = 0;
        if (!rst_n)
            res_ready <= 0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            res_ready <= 0;
        end
        else
        begin
            res_ready <= 1;
            recv_gap = pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && cmd_valid && cmd_ready)
        begin
            beat_taken = 1;
            predict_ranks(cmd);
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_ranks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected rank beat: %p", res);
            end
            else if (res !== expected_ranks[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", expected_ranks[0], res);
                void'(expected_ranks.pop_front());
            end
            else
                void'(expected_ranks.pop_front());
        end
    end

    initial
    begin
        int n;
        int sw;
        int ne;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        cfg_nodes = NODE_COUNT_RST;
        cfg_sweeps = SWEEP_COUNT_RST;
        cfg_damping = DAMPING_RST;
        for (int i = 0; i < 64; i++)
        begin
            adj_rows[i] = 0;
            degree[i] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // cycle, self loop, duplicate, nodes out of use, extremes
        configure(4, 3, 27853);
        push_edge(0, 1);
        push_edge(1, 2);
        push_edge(2, 0);
        push_edge(3, 3);
        push_edge(1, 2);
        push_edge(5, 6);
        push_edge(63, 63);
        push_edge(0, 63);
        push_start();
        // zero sweeps, zero damping
        configure(1, 0, 0);
        push_edge(0, 0);
        push_start();
        // maximum damping with a self loop
        configure(2, 255, 32767);
        push_edge(0, 1);
        push_edge(1, 1);
        push_edge(1, 0);
        push_start();
        // node count zero acts as one
        configure(0, 1, 32767);
        push_start();
        // node count above the limit acts as the limit
        configure(127, 1, 0);
        push_edge(10, 20);
        push_edge(20, 10);
        push_edge(63, 0);
        push_start();
        // dangling graph, no edges
        configure(3, 2, 16384);
        push_start();

        for (int p = 0; p < 18; p++)
        begin
            steady_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                n = 64;
                sw = $urandom_range(1, 2);
            end
            else
            begin
                n = $urandom_range(1, 12);
                sw = $urandom_range(1, 8);
            end
            configure(n, sw, $urandom_range(0, 32767));
            ne = $urandom_range(17, 31);
            for (int e = 0; e < ne; e++)
                if ($urandom_range(0, 9) < 7)
                    push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
                else
                    push_edge($urandom_range(0, 63), $urandom_range(0, 63));
            push_start();
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_ranks.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
